// ----- rtl/core/srd_pkg.sv -----
// shared types and constants for the sort and duplicate removal unit
// no dependencies

package srd_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 16;

	// store index and fill count widths
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	typedef logic [VALUE_WIDTH-1:0] val_t;
	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_EVAL
	} state_t;

	// control into the shared compare unit
	typedef struct packed {
		logic clear;     // start of a new pass
		logic cand_vld;  // candidate read from the store
		val_t cand;
		logic has_floor; // a value has already been picked
		val_t floor;     // candidates must be strictly above this
	} min_ctl_t;

	// result of the current pass
	typedef struct packed {
		logic found;
		val_t best;
	} min_stat_t;

endpackage

// ----- rtl/core/srd_min_unit.sv -----
// shared compare unit: smallest stored value strictly above a floor
// depends on srd_pkg

module srd_min_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srd_pkg::min_ctl_t     ctl,
	output srd_pkg::min_stat_t    stat
);

	logic         found_q;
	srd_pkg::val_t best_q;
	logic         above_floor;
	logic         below_best;
	logic         take;

	// one magnitude compare against the floor, one against the running best
	assign above_floor = !ctl.has_floor || (ctl.cand > ctl.floor);
	assign below_best  = !found_q || (ctl.cand < best_q);
	assign take        = ctl.cand_vld && above_floor && below_best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !ctl.clear) begin
			best_q <= ctl.cand;
		end
	end

	assign stat.found = found_q;
	assign stat.best  = best_q;

endmodule

// ----- rtl/core/sort_and_remove_duplicates_unit.sv -----
// top level of the sort and duplicate removal unit: load store, sequencer, result register
// depends on srd_pkg and srd_min_unit

// Collects up to CAPACITY unsigned values, one transfer per clock while busy is low
// (a transfer happens at each edge with start high and busy low). The transfer with
// last_in set ends the load; busy then rises and the block emits every distinct value
// once, in ascending order, each on the result ports for a single cycle marked by
// strobe, with last_out on the largest. The receiver cannot stall the results, so they
// must be taken as they appear. Values arriving while the store is full are dropped and
// overflow is set on every result of that load. Sorting is done by repeated passes of
// one shared compare unit over the store, each pass picking the smallest value above
// the one picked before: with d distinct stored values there are d + 1 passes, each
// made of a read of every stored value, a compare drain step and a decision step, with
// busy high throughout. The store needs no clearing after reset.

module sort_and_remove_duplicates_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] value,
	input  logic        last_in,
	output logic        strobe,
	output logic [15:0] sorted_value,
	output logic        last_out,
	output logic        overflow
);

	// sequencer state
	srd_pkg::state_t state_q, state_d;

	// load bookkeeping
	srd_pkg::cnt_t count_q;
	logic          dropped_q;

	// scan pointer and read pipeline
	srd_pkg::cnt_t scan_q;
	logic          rd_vld_s1;
	srd_pkg::val_t rd_data_s1;

	// value picked by the previous pass, waiting to be emitted
	logic          have_prev_q;
	srd_pkg::val_t prev_q;

	// result register
	logic          strobe_q;
	srd_pkg::val_t res_val_q;
	logic          res_last_q;
	logic          res_ovf_q;

	// the store itself
	srd_pkg::val_t mem [srd_pkg::CAPACITY];

	srd_pkg::min_ctl_t  min_ctl;
	srd_pkg::min_stat_t min_stat;

	logic transfer;
	logic store_room;
	logic rd_issue;
	logic pass_done;
	logic emit;
	logic emit_last;
	logic next_pass;
	logic finish;

	assign transfer   = start && !busy;
	assign store_room = count_q < srd_pkg::CNT_W'(srd_pkg::CAPACITY);

	// next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		rd_issue  = 1'b0;
		pass_done = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		next_pass = 1'b0;
		finish    = 1'b0;
		case (state_q)
			srd_pkg::ST_LOAD: begin
				busy = 1'b0;
				if (transfer && last_in) begin
					state_d = srd_pkg::ST_SCAN;
				end
			end
			srd_pkg::ST_SCAN: begin
				if (scan_q < count_q) begin
					rd_issue = 1'b1;
				end else begin
					// last read is compared this cycle
					pass_done = 1'b1;
					state_d   = srd_pkg::ST_EVAL;
				end
			end
			srd_pkg::ST_EVAL: begin
				if (min_stat.found) begin
					// a larger value exists, so the pending one is not the last
					emit      = have_prev_q;
					next_pass = 1'b1;
					state_d   = srd_pkg::ST_SCAN;
				end else begin
					// nothing above the pending value: it is the largest
					emit      = 1'b1;
					emit_last = 1'b1;
					finish    = 1'b1;
					state_d   = srd_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = srd_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srd_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// fill count and overflow mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (finish) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (transfer) begin
			if (store_room) begin
				count_q <= count_q + srd_pkg::CNT_W'(1);
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	// store write port
	always_ff @(posedge clk) begin
		if (transfer && store_room) begin
			mem[count_q[srd_pkg::ADDR_W-1:0]] <= srd_pkg::VALUE_WIDTH'(value);
		end
	end

	// store read port, registered data
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_data_s1 <= mem[scan_q[srd_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (rd_issue) begin
				scan_q <= scan_q + srd_pkg::CNT_W'(1);
			end else if (pass_done || state_q == srd_pkg::ST_LOAD) begin
				scan_q <= '0;
			end
		end
	end

	// pending value: floor for the next pass and the next result to go out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (finish) begin
			have_prev_q <= 1'b0;
		end else if (next_pass) begin
			have_prev_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (next_pass) begin
			prev_q <= min_stat.best;
		end
	end

	assign min_ctl.clear     = next_pass || finish;
	assign min_ctl.cand_vld  = rd_vld_s1;
	assign min_ctl.cand      = rd_data_s1;
	assign min_ctl.has_floor = have_prev_q;
	assign min_ctl.floor     = prev_q;

	srd_min_unit u_min (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (min_ctl),
		.stat   (min_stat)
	);

	// result register, loaded with each emitted value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_val_q  <= prev_q;
			res_last_q <= emit_last;
			res_ovf_q  <= dropped_q;
		end
	end

	assign strobe       = strobe_q;
	assign sorted_value = 16'(res_val_q);
	assign last_out     = strobe_q && res_last_q;
	assign overflow     = res_ovf_q;

`ifndef SYNTHESIS
	// results only follow a decision cycle
	a_strobe_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == srd_pkg::ST_EVAL))
		else $error("result without a decision cycle");

	// fill count stays within the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= srd_pkg::CNT_W'(srd_pkg::CAPACITY))
		else $error("fill count beyond capacity");

	// a pass never runs over an empty store
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srd_pkg::ST_SCAN) |-> (count_q != '0))
		else $error("scan over empty store");

	// the final result returns the block to loading with an empty store
	a_last_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_out) |-> (state_q == srd_pkg::ST_LOAD && count_q == '0))
		else $error("final result without return to load");

	// the final decision always has a pending value to emit
	a_eval_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srd_pkg::ST_EVAL && !min_stat.found) |-> have_prev_q)
		else $error("end of run with nothing pending");
`endif

endmodule
